### rtl/gnbm_pkg.sv
`timescale 1ns / 1ps

package gnbm_pkg;

    // Fixed field widths
    localparam int unsigned CFG_IDX_W   = 8;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned COUNT_W     = 9;
    localparam int unsigned STEP_W      = 16;
    localparam int unsigned BEAM_W      = 8;

    // Largest beam count searched; counts above it saturate
    localparam logic [COUNT_W-1:0] MAX_BEAMS = 9'd256;

    // Grid centers stay below 2^24 (255 cells of 65535 plus a half step)
    localparam int unsigned CENTER_W = 24;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BEAM_COUNT   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_X       = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y       = 8'd3;

    // Register reset values
    localparam logic [COUNT_W-1:0] RST_BEAM_COUNT   = 9'd64;
    localparam logic [COUNT_W-1:0] RST_GRID_COLUMNS = 9'd8;
    localparam logic [STEP_W-1:0]  RST_STEP_X       = 16'd4096;
    localparam logic [STEP_W-1:0]  RST_STEP_Y       = 16'd4096;

    // Beam tag traveling alongside the distance pipeline
    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic [BEAM_W-1:0] idx;
    } t_tag;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_ROOT_LOAD,
        ST_ROOT,
        ST_FINISH
    } t_state;

endpackage

### rtl/gnbm_dist.sv
`timescale 1ns / 1ps

module gnbm_dist #(
    parameter int unsigned COORD_BITS = 16,
    parameter int unsigned DW         = 24
) (
    input  logic                          i_clk,
    input  logic [COORD_BITS-1:0]         i_ux,
    input  logic [COORD_BITS-1:0]         i_uy,
    input  logic [gnbm_pkg::CENTER_W-1:0] i_cx,
    input  logic [gnbm_pkg::CENTER_W-1:0] i_cy,
    input  gnbm_pkg::t_tag                i_tag,
    input  logic                          i_rst_n,
    output logic [2*DW-1:0]               o_sq_x,
    output logic [2*DW-1:0]               o_sq_y,
    output gnbm_pkg::t_tag                o_tag
);
    import gnbm_pkg::*;

    logic [DW-1:0] ux_e, uy_e, cx_e, cy_e;
    logic [DW-1:0] r_dx, r_dy;
    logic [2*DW-1:0] r_sq_x, r_sq_y;
    t_tag r_tag1, r_tag2;

    assign ux_e = DW'(i_ux);
    assign uy_e = DW'(i_uy);
    assign cx_e = DW'(i_cx);
    assign cy_e = DW'(i_cy);

    // Stage 1: absolute differences
    always_ff @(posedge i_clk) begin
        r_dx <= (ux_e > cx_e) ? (ux_e - cx_e) : (cx_e - ux_e);
        r_dy <= (uy_e > cy_e) ? (uy_e - cy_e) : (cy_e - uy_e);
    end

    // Stage 2: squares, one multiplier per axis
    always_ff @(posedge i_clk) begin
        r_sq_x <= r_dx * r_dx;
        r_sq_y <= r_dy * r_dy;
    end

    // Tag pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
        end
    end

    assign o_sq_x = r_sq_x;
    assign o_sq_y = r_sq_y;
    assign o_tag  = r_tag2;

endmodule

### rtl/gnbm_isqrt.sv
`timescale 1ns / 1ps

module gnbm_isqrt #(
    parameter int unsigned W = 50
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [W-1:0]   i_value,
    output logic           o_done,
    output logic [W/2-1:0] o_root
);
    import gnbm_pkg::*;

    localparam int unsigned RW = W / 2;

    logic [W-1:0] r_rem, r_root, r_bit;
    logic         r_busy, r_done;
    logic [W:0]   trial;
    logic         take;

    // One result bit per cycle: restoring square root
    assign trial = {1'b0, r_root} + {1'b0, r_bit};
    assign take  = ({1'b0, r_rem} >= trial);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_value;
            r_root <= '0;
            r_bit  <= W'(1) << (W - 2);
        end else if (r_busy) begin
            if (take) begin
                r_rem  <= r_rem - trial[W-1:0];
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // Busy until the bit reaches position zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && r_bit[0];
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root[RW-1:0];

endmodule

### rtl/grid_nearest_beam_match_top.sv
`timescale 1ns / 1ps

// Grid nearest-beam match. Each item (user_x, user_y) yields one result: the
// index of the beam whose grid center is nearest and the floor of the
// Euclidean distance to it, saturated to all ones when it does not fit.
// Centers are generated from beam_count, grid_columns, step_x and step_y;
// lowest index wins ties. The block scans beams one per cycle through a
// pipelined squared-distance unit, then runs a bit-serial square root that
// yields one result bit per cycle. The scan covers the effective beam
// count (zero reads as one, larger counts saturate at 256), and the datapath
// width DW is max(COORD_BITS, 24). Input ready is high only between items
// and returns in the cycle the result appears; one finished result can
// wait in the output register while the next item is accepted.
// Configuration writes are always taken and must happen between items.
module grid_nearest_beam_match_top #(
    parameter int unsigned COORD_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input items
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [COORD_BITS-1:0]           i_user_x,
    input  logic [COORD_BITS-1:0]           i_user_y,
    // Results
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [gnbm_pkg::BEAM_W-1:0]     o_best_beam,
    output logic [COORD_BITS:0]             o_distance,
    // Configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gnbm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gnbm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import gnbm_pkg::*;

    localparam int unsigned DW   = (COORD_BITS > CENTER_W) ? COORD_BITS : CENTER_W;
    localparam int unsigned SQ_W = 2 * DW + 1;
    localparam int unsigned RT_W = 2 * DW + 2;
    localparam int unsigned RW   = RT_W / 2;
    localparam logic [RW-1:0] DIST_MAX = RW'({(COORD_BITS + 1){1'b1}});

    // Configuration registers
    logic [COUNT_W-1:0] r_beam_count, r_grid_columns;
    logic [STEP_W-1:0]  r_step_x, r_step_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beam_count   <= RST_BEAM_COUNT;
            r_grid_columns <= RST_GRID_COLUMNS;
            r_step_x       <= RST_STEP_X;
            r_step_y       <= RST_STEP_Y;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BEAM_COUNT:   r_beam_count   <= i_cfg_data[COUNT_W-1:0];
                CFG_GRID_COLUMNS: r_grid_columns <= i_cfg_data[COUNT_W-1:0];
                CFG_STEP_X:       r_step_x       <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_Y:       r_step_y       <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective count and columns
    logic [COUNT_W-1:0] count_eff, cols_eff;
    always_comb begin
        priority if (r_beam_count == '0) count_eff = COUNT_W'(1);
        else if (r_beam_count > MAX_BEAMS) count_eff = MAX_BEAMS;
        else count_eff = r_beam_count;
        cols_eff = (r_grid_columns == '0) ? COUNT_W'(1) : r_grid_columns;
    end

    // Center generator state
    logic [BEAM_W-1:0]     r_idx;
    logic [COUNT_W-1:0]    r_col;
    logic [CENTER_W-1:0]   r_cx, r_cy;
    logic [COORD_BITS-1:0] r_ux, r_uy;

    // Sequencer
    t_state r_state, n_state;
    logic   in_acc, issue, root_start, out_load, root_done;
    logic   is_last;
    t_tag   tag_in, tag_out;

    assign in_acc  = i_in_valid && o_in_ready;
    assign is_last = ({1'b0, r_idx} == count_eff - COUNT_W'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (i_in_valid) n_state = ST_SCAN;
            ST_SCAN:      if (is_last) n_state = ST_DRAIN;
            ST_DRAIN:     if (tag_out.valid && tag_out.last) n_state = ST_ROOT_LOAD;
            ST_ROOT_LOAD: n_state = ST_ROOT;
            ST_ROOT:      if (root_done) n_state = ST_FINISH;
            ST_FINISH:    if (!o_out_valid || i_out_ready) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        issue      = (r_state == ST_SCAN);
        root_start = (r_state == ST_ROOT_LOAD);
        out_load   = (r_state == ST_FINISH) && (!o_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // Center generator: walks the grid without multiplying
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ux  <= i_user_x;
            r_uy  <= i_user_y;
            r_idx <= '0;
            r_col <= '0;
            r_cx  <= CENTER_W'(r_step_x >> 1);
            r_cy  <= CENTER_W'(r_step_y >> 1);
        end else if (issue && !is_last) begin
            r_idx <= r_idx + BEAM_W'(1);
            if (r_col == cols_eff - COUNT_W'(1)) begin
                r_col <= '0;
                r_cx  <= CENTER_W'(r_step_x >> 1);
                r_cy  <= r_cy + CENTER_W'(r_step_y);
            end else begin
                r_col <= r_col + COUNT_W'(1);
                r_cx  <= r_cx + CENTER_W'(r_step_x);
            end
        end
    end

    always_comb begin
        tag_in.valid = issue;
        tag_in.first = (r_idx == '0);
        tag_in.last  = is_last;
        tag_in.idx   = r_idx;
    end

    // Squared-distance pipeline
    logic [2*DW-1:0] sq_x, sq_y;

    gnbm_dist #(
        .COORD_BITS (COORD_BITS),
        .DW         (DW)
    ) u_dist (
        .i_clk   (i_clk),
        .i_ux    (r_ux),
        .i_uy    (r_uy),
        .i_cx    (r_cx),
        .i_cy    (r_cy),
        .i_tag   (tag_in),
        .i_rst_n (i_rst_n),
        .o_sq_x  (sq_x),
        .o_sq_y  (sq_y),
        .o_tag   (tag_out)
    );

    // Running minimum; strictly less wins
    logic [SQ_W-1:0]   sum_sq, r_best_sq;
    logic [BEAM_W-1:0] r_best_idx;

    assign sum_sq = SQ_W'(sq_x) + SQ_W'(sq_y);

    always_ff @(posedge i_clk) begin
        if (tag_out.valid && (tag_out.first || sum_sq < r_best_sq)) begin
            r_best_sq  <= sum_sq;
            r_best_idx <= tag_out.idx;
        end
    end

    // Square root of the winner
    logic [RW-1:0] root;

    gnbm_isqrt #(
        .W (RT_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_start),
        .i_value (RT_W'(r_best_sq)),
        .o_done  (root_done),
        .o_root  (root)
    );

    // Output register
    logic                r_out_valid;
    logic [BEAM_W-1:0]   r_best_beam;
    logic [COORD_BITS:0] r_distance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_best_beam <= r_best_idx;
            r_distance  <= (root > DIST_MAX) ? '1 : root[COORD_BITS:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_best_beam = r_best_beam;
    assign o_distance  = r_distance;

endmodule

### rtl/gnbm_checker.sv
`timescale 1ns / 1ps

module gnbm_checker #(
    parameter int unsigned COORD_BITS = 16
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [gnbm_pkg::BEAM_W-1:0] o_best_beam,
    input logic [COORD_BITS:0]         o_distance
);
    import gnbm_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_best_beam) && $stable(o_distance))
        else $error("result changed while stalled");

    // Busy right after taking an item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("item accepted while busy");

    // A new result only appears at the end of an item's work
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result without work");

    // No result follows an accept in the very next cycle
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid))
        else $error("result too early");

endmodule

bind grid_nearest_beam_match_top gnbm_checker #(
    .COORD_BITS (COORD_BITS)
) u_gnbm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_best_beam (o_best_beam),
    .o_distance  (o_distance)
);
